### rtl/ftp_pkg.sv
`default_nettype none

package ftp_pkg;

    localparam int GLOBAL_ENTRIES = 4;
    localparam int LOCAL_ENTRIES  = 8;

    localparam int GIDX_W = (GLOBAL_ENTRIES > 1) ? $clog2(GLOBAL_ENTRIES) : 1;
    localparam int LIDX_W = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
    localparam int SLOT_W = 3;
    localparam int WIDE_W = (GIDX_W > LIDX_W) ?
                            ((GIDX_W > SLOT_W) ? GIDX_W : SLOT_W) :
                            ((LIDX_W > SLOT_W) ? LIDX_W : SLOT_W);

    localparam int PORT_W = 16;
    localparam int NODE_W = 16;
    localparam int ADDR_W = 64;
    localparam int OUTC_W = 3;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_SERVER_PORT = '0;

    typedef enum logic [OUTC_W-1:0] {
        OUT_WRONG_PORT     = 3'd0,
        OUT_SPOOFED        = 3'd1,
        OUT_ALREADY_GLOBAL = 3'd2,
        OUT_ALREADY_SEEN   = 3'd3,
        OUT_PROMOTED       = 3'd4,
        OUT_INSERTED       = 3'd5,
        OUT_REPLACED       = 3'd6
    } ftp_outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GSCAN,
        ST_LSCAN,
        ST_EMIT
    } ftp_state_t;

    typedef struct packed {
        logic         load_req;
        logic         g_step;
        logic         l_step;
        logic         commit;
        ftp_outcome_t outcome;
        logic         emit;
    } ftp_cmd_t;

    typedef struct packed {
        logic port_ok;
        logic sender_ok;
        logic g_hit;
        logic g_last;
        logic l_hit;
        logic l_same_node;
        logic l_last;
        logic free_avail;
        logic out_busy;
    } ftp_stat_t;

endpackage

`default_nettype wire

### rtl/ftp_ctrl.sv
`default_nettype none

module ftp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ftp_pkg::ftp_stat_t stat,
    output ftp_pkg::ftp_cmd_t      cmd
);
    import ftp_pkg::*;

    ftp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.outcome = OUT_WRONG_PORT;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!stat.port_ok) begin
                    cmd.commit  = 1'b1;
                    cmd.outcome = OUT_WRONG_PORT;
                    state_next  = ST_EMIT;
                end else if (!stat.sender_ok) begin
                    cmd.commit  = 1'b1;
                    cmd.outcome = OUT_SPOOFED;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_GSCAN;
                end
            end
            ST_GSCAN: begin
                if (stat.g_hit) begin
                    cmd.commit  = 1'b1;
                    cmd.outcome = OUT_ALREADY_GLOBAL;
                    state_next  = ST_EMIT;
                end else if (stat.g_last) begin
                    state_next = ST_LSCAN;
                end else begin
                    cmd.g_step = 1'b1;
                end
            end
            ST_LSCAN: begin
                if (stat.l_hit) begin
                    cmd.commit  = 1'b1;
                    cmd.outcome = stat.l_same_node ? OUT_ALREADY_SEEN : OUT_PROMOTED;
                    state_next  = ST_EMIT;
                end else if (stat.l_last) begin
                    cmd.l_step  = 1'b1;
                    cmd.commit  = 1'b1;
                    cmd.outcome = stat.free_avail ? OUT_INSERTED : OUT_REPLACED;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.l_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ftp_datapath.sv
`default_nettype none

module ftp_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ftp_pkg::ftp_cmd_t                  cmd,
    output ftp_pkg::ftp_stat_t                      stat,
    input  wire logic [ftp_pkg::PORT_W-1:0]         server_port,
    input  wire logic [ftp_pkg::PORT_W-1:0]         in_dest_port,
    input  wire logic [ftp_pkg::NODE_W-1:0]         in_sender_node,
    input  wire logic [ftp_pkg::NODE_W-1:0]         in_node_id,
    input  wire logic [ftp_pkg::ADDR_W-1:0]         in_addr_high,
    input  wire logic [ftp_pkg::ADDR_W-1:0]         in_addr_low,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [ftp_pkg::OUTC_W-1:0]              out_outcome,
    output logic [ftp_pkg::SLOT_W-1:0]              out_slot
);
    import ftp_pkg::*;

    localparam logic [GIDX_W-1:0] G_LAST = GIDX_W'(GLOBAL_ENTRIES - 1);
    localparam logic [LIDX_W-1:0] L_LAST = LIDX_W'(LOCAL_ENTRIES - 1);

    logic [PORT_W-1:0] req_port_reg;
    logic [NODE_W-1:0] req_sender_reg;
    logic [NODE_W-1:0] req_node_reg;
    logic [ADDR_W-1:0] req_high_reg;
    logic [ADDR_W-1:0] req_low_reg;

    logic [ADDR_W-1:0] g_high_reg [GLOBAL_ENTRIES];
    logic [ADDR_W-1:0] g_low_reg  [GLOBAL_ENTRIES];
    logic [GLOBAL_ENTRIES-1:0] g_vld_reg, g_vld_next;
    logic [GIDX_W-1:0] g_ptr_reg, g_ptr_next;
    logic [GIDX_W-1:0] g_idx_reg, g_idx_next;

    logic [ADDR_W-1:0] l_high_reg [LOCAL_ENTRIES];
    logic [ADDR_W-1:0] l_low_reg  [LOCAL_ENTRIES];
    logic [NODE_W-1:0] l_node_reg [LOCAL_ENTRIES];
    logic [LOCAL_ENTRIES-1:0] l_used_reg, l_used_next;
    logic [LIDX_W-1:0] l_ptr_reg, l_ptr_next;
    logic [LIDX_W-1:0] l_idx_reg, l_idx_next;
    logic              have_free_reg, have_free_next;
    logic [LIDX_W-1:0] free_slot_reg, free_slot_next;

    logic [OUTC_W-1:0] res_outcome_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              m_valid_reg, m_valid_next;
    logic [OUTC_W-1:0] m_outcome_reg;
    logic [SLOT_W-1:0] m_slot_reg;

    logic [ADDR_W-1:0] g_rd_high, g_rd_low;
    logic              cur_used;
    logic [LIDX_W-1:0] ins_slot;
    logic              l_wr;
    logic [LIDX_W-1:0] l_wr_idx;
    logic              g_wr;
    logic [WIDE_W-1:0] slot_wide;

    assign g_rd_high = g_vld_reg[g_idx_reg] ? g_high_reg[g_idx_reg] : '0;
    assign g_rd_low  = g_vld_reg[g_idx_reg] ? g_low_reg[g_idx_reg]  : '0;
    assign cur_used  = l_used_reg[l_idx_reg];
    assign ins_slot  = have_free_reg ? free_slot_reg : l_idx_reg;

    always_comb begin
        stat.port_ok     = (req_port_reg == server_port);
        stat.sender_ok   = (req_sender_reg == req_node_reg);
        stat.g_hit       = (g_rd_high == req_high_reg) && (g_rd_low == req_low_reg);
        stat.g_last      = (g_idx_reg == G_LAST);
        stat.l_hit       = cur_used && (l_high_reg[l_idx_reg] == req_high_reg) &&
                           (l_low_reg[l_idx_reg] == req_low_reg);
        stat.l_same_node = (l_node_reg[l_idx_reg] == req_node_reg);
        stat.l_last      = (l_idx_reg == L_LAST);
        stat.free_avail  = have_free_reg || !cur_used;
        stat.out_busy    = m_valid_reg && !out_ready;
    end

    always_comb begin
        g_idx_next     = g_idx_reg;
        l_idx_next     = l_idx_reg;
        have_free_next = have_free_reg;
        free_slot_next = free_slot_reg;
        g_vld_next     = g_vld_reg;
        g_ptr_next     = g_ptr_reg;
        l_used_next    = l_used_reg;
        l_ptr_next     = l_ptr_reg;
        g_wr           = 1'b0;
        l_wr           = 1'b0;
        l_wr_idx       = l_idx_reg;
        slot_wide      = '0;
        m_valid_next   = m_valid_reg && !out_ready;

        if (cmd.load_req) begin
            g_idx_next     = '0;
            l_idx_next     = '0;
            have_free_next = 1'b0;
        end
        if (cmd.g_step) begin
            g_idx_next = g_idx_reg + 1'b1;
        end
        if (cmd.l_step) begin
            if (!cur_used && !have_free_reg) begin
                have_free_next = 1'b1;
                free_slot_next = l_idx_reg;
            end
            if (!stat.l_last) begin
                l_idx_next = l_idx_reg + 1'b1;
            end
        end

        if (cmd.commit) begin
            case (cmd.outcome)
                OUT_ALREADY_GLOBAL: begin
                    slot_wide = WIDE_W'(g_idx_reg);
                end
                OUT_ALREADY_SEEN: begin
                    slot_wide = WIDE_W'(l_idx_reg);
                end
                OUT_PROMOTED: begin
                    g_wr                   = 1'b1;
                    g_vld_next[g_ptr_reg]  = 1'b1;
                    g_ptr_next             = (g_ptr_reg == G_LAST) ? '0 : g_ptr_reg + 1'b1;
                    l_used_next[l_idx_reg] = 1'b0;
                    slot_wide              = WIDE_W'(g_ptr_reg);
                end
                OUT_INSERTED: begin
                    l_wr                  = 1'b1;
                    l_wr_idx              = ins_slot;
                    l_used_next[ins_slot] = 1'b1;
                    slot_wide             = WIDE_W'(ins_slot);
                end
                OUT_REPLACED: begin
                    l_wr                   = 1'b1;
                    l_wr_idx               = l_ptr_reg;
                    l_used_next[l_ptr_reg] = 1'b1;
                    l_ptr_next             = (l_ptr_reg == L_LAST) ? '0 : l_ptr_reg + 1'b1;
                    slot_wide              = WIDE_W'(l_ptr_reg);
                end
                default: begin
                    slot_wide = '0;
                end
            endcase
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg     <= '0;
            g_ptr_reg     <= '0;
            l_used_reg    <= '0;
            l_ptr_reg     <= '0;
            g_idx_reg     <= '0;
            l_idx_reg     <= '0;
            have_free_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            g_vld_reg     <= g_vld_next;
            g_ptr_reg     <= g_ptr_next;
            l_used_reg    <= l_used_next;
            l_ptr_reg     <= l_ptr_next;
            g_idx_reg     <= g_idx_next;
            l_idx_reg     <= l_idx_next;
            have_free_reg <= have_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        free_slot_reg <= free_slot_next;
        if (cmd.load_req) begin
            req_port_reg   <= in_dest_port;
            req_sender_reg <= in_sender_node;
            req_node_reg   <= in_node_id;
            req_high_reg   <= in_addr_high;
            req_low_reg    <= in_addr_low;
        end
        if (g_wr) begin
            g_high_reg[g_ptr_reg] <= req_high_reg;
            g_low_reg[g_ptr_reg]  <= req_low_reg;
        end
        if (l_wr) begin
            l_high_reg[l_wr_idx] <= req_high_reg;
            l_low_reg[l_wr_idx]  <= req_low_reg;
            l_node_reg[l_wr_idx] <= req_node_reg;
        end
        if (cmd.commit) begin
            res_outcome_reg <= cmd.outcome;
            res_slot_reg    <= slot_wide[SLOT_W-1:0];
        end
        if (cmd.emit) begin
            m_outcome_reg <= res_outcome_reg;
            m_slot_reg    <= res_slot_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_outcome = m_outcome_reg;
    assign out_slot    = m_slot_reg;

`ifndef NO_ASSERTIONS
    a_emit_into_free_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid_reg && !out_ready))
        else $error("result overwrote a pending transfer");

    a_promote_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && cmd.outcome == OUT_PROMOTED) |=> !l_used_reg[$past(l_idx_reg)])
        else $error("promoted address left its local slot in use");

    a_reject_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (cmd.outcome == OUT_WRONG_PORT || cmd.outcome == OUT_SPOOFED))
        |=> res_slot_reg == '0)
        else $error("rejected request reported a nonzero slot");

    a_insert_sets_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (cmd.outcome == OUT_INSERTED || cmd.outcome == OUT_REPLACED))
        |=> l_used_reg[$past(l_wr_idx)])
        else $error("written local slot not marked used");
`endif

endmodule

`default_nettype wire

### rtl/filter_table_promoter_unit.sv
// Channel   Dir  Handshake         Payload
// s_*       in   tvalid/tready     request: port, sender, node, 128-bit address
// m_*       out  tvalid/tready     result: outcome, slot
// APB       in   psel/penable      server_port at byte address 0
//
// Request to result: IDLE, CHECK, the global scan (G = 4 global entries), the local scan
// (L = 8 local entries) and EMIT; the table scan compares one entry per cycle.
// Rejected requests skip both scans; one request is in flight at a time.
// A finished result waits in the output register while the next request is taken.
// aresetn is synchronous; it clears the used and valid bits, no clearing pass.
`default_nettype none

module filter_table_promoter_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // dest_port, sender_node, node_id, block_addr_high, block_addr_low
    input  wire logic [ftp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // outcome, slot, zero pad
    output logic [ftp_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ftp_pkg::APB_AW-1:0]     paddr,
    input  wire logic [ftp_pkg::APB_DW-1:0]     pwdata,
    output logic [ftp_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import ftp_pkg::*;

    logic [PORT_W-1:0] server_port_reg;
    ftp_cmd_t          cmd;
    ftp_stat_t         stat;
    logic [OUTC_W-1:0] res_outcome;
    logic [SLOT_W-1:0] res_slot;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_SERVER_PORT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_port_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            server_port_reg <= pwdata[PORT_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(APB_DW-PORT_W){1'b0}}, server_port_reg} : '0;

    ftp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ftp_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .server_port    (server_port_reg),
        .in_dest_port   (s_tdata[15:0]),
        .in_sender_node (s_tdata[31:16]),
        .in_node_id     (s_tdata[47:32]),
        .in_addr_high   (s_tdata[111:48]),
        .in_addr_low    (s_tdata[175:112]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_outcome    (res_outcome),
        .out_slot       (res_slot)
    );

    assign m_tdata = {{(M_TDATA_W-OUTC_W-SLOT_W){1'b0}}, res_slot, res_outcome};

endmodule

`default_nettype wire
